/* rtl/assert_macros.svh */
// assertion macros for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define WSS_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("%m: property failed");

// expression must never be true outside reset
`define WSS_ASSERT_NEVER(name, clk, rst, expr) \
   name: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("%m: forbidden condition seen");

`endif

/* rtl/wss_pkg.sv */
// types and constants for the windowed sample statistics core
package wss_pkg;

   localparam int DEFAULT_WINDOW = 20;

   localparam int SAMPLE_W   = 16;
   localparam int SUM_W      = 24;
   localparam int SQ_W       = 39;
   localparam int NUM_W      = 47;
   localparam int PROD_W     = NUM_W + 1;
   localparam int MEAN_W     = 16;
   localparam int VAR_W      = 31;
   localparam int ENERGY_W   = 35;
   localparam int ROOT_OUT_W = 18;
   localparam int ROOT_W     = 20;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       series_end;
   } req_type;

   typedef struct packed {
      logic signed [MEAN_W-1:0] window_mean;
      logic [VAR_W-1:0]         window_variance;
      logic [ENERGY_W-1:0]      window_energy;
      logic [ROOT_OUT_W-1:0]    window_root_energy;
   } rsp_type;

   typedef struct packed {
      logic accept;
      logic mul_go;
      logic num_go;
      logic var_go;
      logic load;
   } cmd_type;

   typedef struct packed {
      logic window_full;
      logic mean_busy;
      logic var_busy;
      logic root_busy;
   } status_type;

endpackage

/* rtl/wss_div.sv */
// division by a constant through reciprocal multiplication, four partial products accumulated in turn
module wss_div #(
   parameter int DVD_W   = 24,
   parameter int DIVISOR = 20
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   output logic             busy,
   output logic [DVD_W-1:0] quotient
);

   // floor(n * RECIP / 2^SH) equals floor(n / DIVISOR) for every n below 2^DVD_W
   localparam int SH      = DVD_W + $clog2(DIVISOR);
   localparam int RECIP_W = DVD_W + 2;
   localparam longint unsigned RECIP_L = ((64'd1 << SH) / 64'(DIVISOR)) + 64'd1;
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);
   localparam int A_LO_W  = (DVD_W + 1) / 2;
   localparam int A_HI_W  = DVD_W - A_LO_W;
   localparam int B_LO_W  = (RECIP_W + 1) / 2;
   localparam int B_HI_W  = RECIP_W - B_LO_W;
   localparam int PP_W    = A_LO_W + B_LO_W;
   localparam int ACC_W   = DVD_W + RECIP_W;

   logic              busy_ff;
   logic [1:0]        step_ff;
   logic [DVD_W-1:0]  dvd_ff;
   logic [ACC_W-1:0]  acc_ff;
   logic [A_LO_W-1:0] a_part;
   logic [B_LO_W-1:0] b_part;
   logic [PP_W-1:0]   pp;
   logic [ACC_W-1:0]  pp_ext;
   logic [ACC_W-1:0]  pp_sh;

   // step bit 1 picks the dividend half, bit 0 the reciprocal half
   assign a_part = step_ff[1] ? A_LO_W'(dvd_ff[DVD_W-1 -: A_HI_W]) : dvd_ff[A_LO_W-1:0];
   assign b_part = step_ff[0] ? B_LO_W'(RECIP[RECIP_W-1 -: B_HI_W]) : RECIP[B_LO_W-1:0];
   assign pp     = a_part * b_part;
   assign pp_ext = ACC_W'(pp);

   always_comb begin
      unique case (step_ff)
         2'd0: pp_sh = pp_ext;
         2'd1: pp_sh = pp_ext << B_LO_W;
         2'd2: pp_sh = pp_ext << A_LO_W;
         2'd3: pp_sh = pp_ext << (A_LO_W + B_LO_W);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         step_ff <= '0;
      end else if (busy_ff) begin
         step_ff <= step_ff + 2'd1;
         if (step_ff == 2'd3) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         dvd_ff <= dividend;
         acc_ff <= '0;
      end else if (busy_ff) begin
         acc_ff <= acc_ff + pp_sh;
      end
   end

   assign busy     = busy_ff;
   assign quotient = DVD_W'(acc_ff >> SH);

endmodule

/* rtl/wss_sqrt.sv */
// integer square root, two radicand bits per cycle
module wss_sqrt (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [wss_pkg::SQ_W-1:0] value,
   output logic                   busy,
   output logic [wss_pkg::ROOT_W-1:0] root
);

   import wss_pkg::*;

   localparam int RAD_W = 2 * ROOT_W;
   localparam int REM_W = ROOT_W + 4;
   localparam int CNT_W = $clog2(ROOT_W + 1);

   logic              busy_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [RAD_W-1:0]  rad_ff;
   logic [REM_W-1:0]  rem_ff;
   logic [REM_W-1:0]  rem_in;
   logic [REM_W-1:0]  rem_t;
   logic [REM_W-1:0]  trial;
   logic [ROOT_W-1:0] root_ff;
   logic              fits;

   // bring down the next bit pair and try root*4+1
   assign rem_t  = {rem_ff[REM_W-3:0], rad_ff[RAD_W-1 -: 2]};
   assign trial  = {{(REM_W-ROOT_W-2){1'b0}}, root_ff, 2'b01};
   assign fits   = rem_t >= trial;
   assign rem_in = fits ? (rem_t - trial) : rem_t;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= CNT_W'(ROOT_W);
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rad_ff  <= {{(RAD_W-SQ_W){1'b0}}, value};
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (busy_ff) begin
         rad_ff  <= {rad_ff[RAD_W-3:0], 2'b00};
         rem_ff  <= rem_in;
         root_ff <= {root_ff[ROOT_W-2:0], fits};
      end
   end

   assign busy = busy_ff;
   assign root = root_ff;

endmodule

/* rtl/wss_dp.sv */
// datapath: accumulators, window snapshot, products, dividers, root and result register
module wss_dp #(
   parameter int WINDOW = wss_pkg::DEFAULT_WINDOW
) (
   input  logic                clock,
   input  logic                reset,
   input  wss_pkg::cmd_type    cmd,
   input  wss_pkg::req_type    req_data,
   output wss_pkg::status_type status,
   output wss_pkg::rsp_type    rsp_data
);

   import wss_pkg::*;

   localparam int CNT_W  = $clog2(WINDOW);
   localparam int MDVS_W = $clog2(WINDOW + 1);

   localparam logic [CNT_W-1:0]  LAST_CNT   = CNT_W'(WINDOW - 1);
   localparam logic [MDVS_W-1:0] WIN_VEC    = MDVS_W'(WINDOW);

   logic [CNT_W-1:0]        cnt_ff;
   logic signed [SUM_W-1:0] sum_ff;
   logic signed [SUM_W-1:0] sum_in;
   logic [SQ_W-1:0]         sq_ff;
   logic [SQ_W-1:0]         sq_in;
   logic signed [2*SAMPLE_W-1:0] x_sq;
   logic                    full;

   logic signed [SUM_W-1:0] sum_win_ff;
   logic [SQ_W-1:0]         sq_win_ff;
   logic [SUM_W-1:0]        sum_mag;
   logic [PROD_W-1:0]       wsq_ff;
   logic [PROD_W-1:0]       wsq_in;
   logic [PROD_W-1:0]       ssq_ff;
   logic [PROD_W-1:0]       ssq_in;
   logic [PROD_W:0]         diff;
   logic [NUM_W-1:0]        num_ff;
   logic [NUM_W-1:0]        num_in;

   logic [SUM_W-1:0]        mean_quo;
   logic [NUM_W-1:0]        var_quo;
   logic [ROOT_W-1:0]       root_val;
   logic                    mean_busy;
   logic                    var_busy;
   logic                    root_busy;

   logic [MEAN_W-1:0]       mean_mag;
   rsp_type                 rsp_in;
   rsp_type                 rsp_ff;

   assign full   = cnt_ff == LAST_CNT;
   assign x_sq   = req_data.sample * req_data.sample;
   assign sum_in = sum_ff + SUM_W'(req_data.sample);
   assign sq_in  = sq_ff + SQ_W'(unsigned'(x_sq));

   // window totals are captured on the closing sample, then the running sums clear
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         sum_ff <= '0;
         sq_ff  <= '0;
      end else if (cmd.accept) begin
         if (full || req_data.series_end) begin
            cnt_ff <= '0;
            sum_ff <= '0;
            sq_ff  <= '0;
         end else begin
            cnt_ff <= cnt_ff + CNT_W'(1);
            sum_ff <= sum_in;
            sq_ff  <= sq_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept && full) begin
         sum_win_ff <= sum_in;
         sq_win_ff  <= sq_in;
      end
   end

   assign sum_mag = sum_win_ff[SUM_W-1] ? (~sum_win_ff + SUM_W'(1)) : sum_win_ff;
   assign wsq_in  = sq_win_ff * WIN_VEC;
   assign ssq_in  = sum_mag * sum_mag;

   // W*sumsq - sum^2, clamped at zero
   assign diff   = {1'b0, wsq_ff} - {1'b0, ssq_ff};
   assign num_in = diff[PROD_W] ? '0 : diff[NUM_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.mul_go) begin
         wsq_ff <= wsq_in;
         ssq_ff <= ssq_in;
      end
      if (cmd.num_go) begin
         num_ff <= num_in;
      end
   end

   wss_div #(
      .DVD_W  (SUM_W),
      .DIVISOR(WINDOW)
   ) u_mean_div (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.mul_go),
      .dividend(sum_mag),
      .busy    (mean_busy),
      .quotient(mean_quo)
   );

   wss_div #(
      .DVD_W  (NUM_W),
      .DIVISOR(WINDOW * WINDOW)
   ) u_var_div (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.var_go),
      .dividend(num_ff),
      .busy    (var_busy),
      .quotient(var_quo)
   );

   wss_sqrt u_sqrt (
      .clock(clock),
      .reset(reset),
      .start(cmd.mul_go),
      .value(sq_win_ff),
      .busy (root_busy),
      .root (root_val)
   );

   // mean truncates toward zero: divide the magnitude, then restore the sign
   assign mean_mag = mean_quo[MEAN_W-1:0];

   always_comb begin
      rsp_in.window_mean     = sum_win_ff[SUM_W-1] ? (~mean_mag + MEAN_W'(1)) : mean_mag;
      rsp_in.window_variance = var_quo[VAR_W-1:0];
      rsp_in.window_energy   = (|sq_win_ff[SQ_W-1:ENERGY_W]) ? '1 : sq_win_ff[ENERGY_W-1:0];
      rsp_in.window_root_energy =
         (|root_val[ROOT_W-1:ROOT_OUT_W]) ? '1 : root_val[ROOT_OUT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign status.window_full = full;
   assign status.mean_busy   = mean_busy;
   assign status.var_busy    = var_busy;
   assign status.root_busy   = root_busy;
   assign rsp_data           = rsp_ff;

endmodule

/* rtl/wss_ctrl.sv */
// controller: sample intake, window finishing sequence and result handshake
module wss_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  wss_pkg::status_type status,
   output wss_pkg::cmd_type    cmd
);

   import wss_pkg::*;

   `include "assert_macros.svh"

   typedef enum logic [2:0] {
      ACCUM_ST,
      MUL_ST,
      NUM_ST,
      VAR_ST,
      WAIT_ST
   } state_type;

   state_type state_ff;
   logic      req_ready_ff;
   logic      rsp_valid_ff;
   logic      accept;
   logic      units_idle;
   logic      slot_free;
   logic      load_go;

   assign accept     = req_valid && req_ready_ff;
   assign units_idle = !status.mean_busy && !status.var_busy && !status.root_busy;
   assign slot_free  = !rsp_valid_ff || rsp_ready;
   assign load_go    = (state_ff == WAIT_ST) && units_idle && slot_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ACCUM_ST;
         req_ready_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // a new result may replace the one leaving in the same cycle
         if (load_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ACCUM_ST: begin
               if (accept && status.window_full) begin
                  state_ff     <= MUL_ST;
                  req_ready_ff <= 1'b0;
               end else begin
                  req_ready_ff <= 1'b1;
               end
            end
            MUL_ST: begin
               state_ff <= NUM_ST;
            end
            NUM_ST: begin
               state_ff <= VAR_ST;
            end
            VAR_ST: begin
               state_ff <= WAIT_ST;
            end
            WAIT_ST: begin
               if (load_go) begin
                  state_ff     <= ACCUM_ST;
                  req_ready_ff <= 1'b1;
               end
            end
            default: begin
               state_ff <= ACCUM_ST;
            end
         endcase
      end
   end

   assign cmd.accept = accept;
   assign cmd.mul_go = state_ff == MUL_ST;
   assign cmd.num_go = state_ff == NUM_ST;
   assign cmd.var_go = state_ff == VAR_ST;
   assign cmd.load   = load_go;

   assign req_ready = req_ready_ff;
   assign rsp_valid = rsp_valid_ff;

   `WSS_ASSERT(a_ready_only_accum, clock, reset, req_ready_ff |-> (state_ff == ACCUM_ST))
   `WSS_ASSERT(a_close_stalls_input, clock, reset,
      (accept && status.window_full) |=> (!req_ready_ff && state_ff == MUL_ST))
   `WSS_ASSERT(a_load_shows_result, clock, reset, load_go |=> (rsp_valid_ff && req_ready_ff))
   `WSS_ASSERT_NEVER(a_load_while_unit_busy, clock, reset,
      load_go && (status.mean_busy || status.var_busy || status.root_busy))

endmodule

/* rtl/windowed_sample_statistics_core.sv */
// Windowed sample statistics core: takes one signed sample per transfer and, for every
// complete non-overlapping window of WINDOW samples, returns the truncated mean, the
// floored population variance, the energy (saturating at 35 bits) and the floored square
// root of the true energy. A sample flagged series_end drops any partial window. Samples
// are taken one per cycle while a window fills. The transfer that closes a window holds
// the input off through the states MUL (products formed, mean division and square root
// started, two radicand bits per cycle), NUM (variance numerator), VAR (variance
// division started) and WAIT (result register loaded once all units are idle and the
// output register is free). The mean and variance divisions, by the constants WINDOW
// and WINDOW*WINDOW, are reciprocal multiplications of four partial products each. The
// result sits in an output register, so sampling resumes while it waits to be taken;
// the next result waits until that register is free, lengthening that window's stall.
module windowed_sample_statistics_core #(
   parameter int WINDOW = wss_pkg::DEFAULT_WINDOW
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  wss_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output wss_pkg::rsp_type rsp_data
);

   import wss_pkg::*;

   cmd_type    cmd;
   status_type status;

   wss_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .status   (status),
      .cmd      (cmd)
   );

   wss_dp #(
      .WINDOW(WINDOW)
   ) u_dp (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .req_data(req_data),
      .status  (status),
      .rsp_data(rsp_data)
   );

endmodule

/* bench/tb_windowed_sample_statistics_core.sv */
`timescale 1ns / 1ps
// self-checking testbench for the windowed sample statistics core
module tb_windowed_sample_statistics_core;
   import wss_pkg::*;

   localparam int WIN          = DEFAULT_WINDOW;
   localparam int TARGET_ITEMS = 1900;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 80;
   localparam longint unsigned ENERGY_CAP = (64'd1 << ENERGY_W) - 1;
   localparam longint unsigned ROOT_CAP   = (64'd1 << ROOT_OUT_W) - 1;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7fff;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

   logic    clock;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   windowed_sample_statistics_core #(.WINDOW(WIN)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // running window accumulators of the predictor
   longint          win_sum;
   longint unsigned win_energy;
   int              win_fill;

   rsp_type window_stats_q[$];
   int      error_count  = 0;
   int      items_sent   = 0;
   int      windows_seen = 0;
   int      burst_left   = 0;
   int      cycle_count  = 0;

   function automatic longint unsigned floor_sqrt(input longint unsigned v);
      longint unsigned lo, hi, mid;
      lo = 0;
      hi = 64'd1 << 32;
      while (hi - lo > 1) begin
         mid = (lo + hi) >> 1;
         if (mid * mid <= v) lo = mid;
         else hi = mid;
      end
      return lo;
   endfunction

   function automatic void clear_window();
      win_sum    = 0;
      win_energy = 0;
      win_fill   = 0;
   endfunction

   // adds one sample; returns 1 with the window statistics when a window closes
   function automatic bit window_statistics(input req_type item, output rsp_type stats);
      longint          x, mean, num, var_full;
      longint unsigned energy, root;
      bit              closed;
      x = longint'($signed(item.sample));
      closed = 1'b0;
      stats = '0;
      win_sum    += x;
      win_energy += longint'(x * x);
      win_fill++;
      if (win_fill >= WIN) begin
         mean = win_sum / WIN;
         num = WIN * longint'(win_energy) - win_sum * win_sum;
         if (num < 0) num = 0;
         var_full = num / (WIN * WIN);
         energy = (win_energy > ENERGY_CAP) ? ENERGY_CAP : win_energy;
         root = floor_sqrt(win_energy);
         if (root > ROOT_CAP) root = ROOT_CAP;
         stats.window_mean        = mean[MEAN_W-1:0];
         stats.window_variance    = var_full[VAR_W-1:0];
         stats.window_energy      = energy[ENERGY_W-1:0];
         stats.window_root_energy = root[ROOT_OUT_W-1:0];
         closed = 1'b1;
         clear_window();
      end
      if (item.series_end) clear_window();
      return closed;
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] random_sample();
      int pick;
      pick = $urandom_range(0, 19);
      if (pick < 12) return SAMPLE_W'($urandom());
      if (pick < 17) return SAMPLE_W'(int'($urandom_range(0, 511)) - 256);
      case ($urandom_range(0, 4))
         0: return SAMPLE_MIN;
         1: return SAMPLE_MAX;
         2: return '0;
         3: return -16'sd1;
         default: return 16'sd1;
      endcase
   endfunction

   // one sample transfer, then possibly a gap before the next burst
   task automatic send_sample(input logic signed [SAMPLE_W-1:0] value, input logic last);
      req_type item;
      rsp_type stats;
      int      gap;
      item.sample     = value;
      item.series_end = last;
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      if (window_statistics(item, stats)) window_stats_q.push_back(stats);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = $urandom_range(0, 6);
         burst_left = $urandom_range(0, 40);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic test_full_scale_window();
      for (int i = 0; i < WIN; i++) send_sample(SAMPLE_MIN, 1'b0);
   endtask

   // alternating extremes give the largest variance; flag lands on the closing sample
   task automatic test_series_end_on_full_window();
      for (int i = 0; i < WIN; i++)
         send_sample((i % 2) ? SAMPLE_MAX : SAMPLE_MIN, i == WIN - 1);
   endtask

   // partial window must vanish, then a small negative sum checks truncation toward zero
   task automatic test_partial_window_dropped();
      for (int i = 0; i < 7; i++) send_sample(SAMPLE_MAX, i == 6);
      send_sample(SAMPLE_MIN, 1'b1);
      for (int i = 0; i < WIN; i++) send_sample((i == 3) ? -16'sd1 : 16'sd0, 1'b0);
   endtask

   task automatic test_random_series();
      int kind, n, tail;
      logic last;
      while (items_sent < TARGET_ITEMS) begin
         kind = $urandom_range(0, 9);
         if (kind <= 6) begin
            // well-formed series: whole windows, maybe a tail, maybe an end flag
            tail = (kind >= 2 && kind <= 4) ? $urandom_range(1, WIN - 1) : 0;
            n = $urandom_range(1, 3) * WIN + tail;
            for (int i = 0; i < n; i++) send_sample(random_sample(), (i == n - 1) && kind <= 4);
         end else if (kind <= 8) begin
            n = $urandom_range(1, 30);
            for (int i = 0; i < n; i++) begin
               last = (i == n - 1) || ($urandom_range(0, 7) == 0);
               send_sample(random_sample(), last);
            end
         end else begin
            send_sample(random_sample(), 1'b1);
         end
      end
   endtask

   // receiver stall pattern: free-running, coin flip, or mostly stalled
   int stall_mode = 0;
   int mode_left  = 0;
   always @(posedge clock) begin
      if (mode_left == 0) begin
         stall_mode = $urandom_range(0, 2);
         mode_left  = $urandom_range(20, 200);
      end else begin
         mode_left--;
      end
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= 1'($urandom_range(0, 1));
         default: rsp_ready <= ($urandom_range(0, 7) == 0);
      endcase
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (window_stats_q.size() == 0) begin
            $error("window result transfer with no window pending");
            error_count++;
         end else begin
            want = window_stats_q.pop_front();
            windows_seen++;
            if (rsp_data.window_mean !== want.window_mean) begin
               $error("window_mean: expected %0d, actual %0d",
                      want.window_mean, rsp_data.window_mean);
               error_count++;
            end
            if (rsp_data.window_variance !== want.window_variance) begin
               $error("window_variance: expected %0d, actual %0d",
                      want.window_variance, rsp_data.window_variance);
               error_count++;
            end
            if (rsp_data.window_energy !== want.window_energy) begin
               $error("window_energy: expected %0d, actual %0d",
                      want.window_energy, rsp_data.window_energy);
               error_count++;
            end
            if (rsp_data.window_root_energy !== want.window_root_energy) begin
               $error("window_root_energy: expected %0d, actual %0d",
                      want.window_root_energy, rsp_data.window_root_energy);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      clear_window();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_full_scale_window();
      test_series_end_on_full_window();
      test_partial_window_dropped();
      test_random_series();
      req_valid <= 1'b0;
      while (window_stats_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
